// File: rtl/assert_macros.svh
// Assertion helpers used by the RTL file frt_back.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that an expression never holds.
`define ASSERT_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

// File: rtl/frt_pkg.sv
// ----------------------------------------------------------------------------
// frt_pkg
// Types and constants of the fragment reassembly tracker.
// ----------------------------------------------------------------------------
package frt_pkg;

    localparam int TABLE_SLOTS_DEF  = 16;
    localparam int MAX_PARTS_DEF    = 64;
    localparam int HEADER_BYTES_DEF = 24;

    localparam logic [47:0] TIMEOUT_RESET = 48'd1000000;
    localparam logic [4:0]  LIMIT_RESET   = 5'd16;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_LIMIT   = 1'b1;

    typedef enum logic [2:0] {
        ST_SHORT    = 3'd0,
        ST_BAD      = 3'd1,
        ST_DUP      = 3'd2,
        ST_STORED   = 3'd3,
        ST_COMPLETE = 3'd4
    } status_t;

    // Classified fragment handed from front to back.
    typedef struct packed {
        logic        reject;
        status_t     status;
        logic [31:0] stream_id;
        logic [63:0] frame_number;
        logic [7:0]  part_index;
        logic [7:0]  part_total;
        logic [15:0] payload;
        logic [47:0] now_time;
    } frag_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_LOOKUP,
        B_PURGE,
        B_EVICT,
        B_APPLY,
        B_OUT
    } bstate_t;

endpackage

// File: rtl/frt_front.sv
// ----------------------------------------------------------------------------
// frt_front
// Accepts fragments, marks short or malformed ones as rejected and queues them all.
// ----------------------------------------------------------------------------
module frt_front #(
    parameter int MAX_PARTS    = frt_pkg::MAX_PARTS_DEF,
    parameter int HEADER_BYTES = frt_pkg::HEADER_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [31:0]  s_stream_id,
    input  logic [63:0]  s_frame_number,
    input  logic [7:0]   s_part_index,
    input  logic [7:0]   s_part_total,
    input  logic [15:0]  s_packet_bytes,
    input  logic [47:0]  s_now_time,
    output logic         q_valid,
    input  logic         q_ready,
    output frt_pkg::frag_t q_data
);
    import frt_pkg::*;

    // Two-entry queue.
    frag_t q_mem_reg [2];
    logic  wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    frag_t f;
    logic push, pop;

    always_comb begin
        f.stream_id    = s_stream_id;
        f.frame_number = s_frame_number;
        f.part_index   = s_part_index;
        f.part_total   = s_part_total;
        f.payload      = s_packet_bytes - 16'(HEADER_BYTES);
        f.now_time     = s_now_time;
        f.reject       = 1'b1;
        priority if ({1'b0, s_packet_bytes} < 17'(HEADER_BYTES)) begin
            f.status = ST_SHORT;
        end else if (s_part_total == 8'd0 || 9'(s_part_total) > 9'(MAX_PARTS)
                     || s_part_index >= s_part_total) begin
            f.status = ST_BAD;
        end else begin
            f.status = ST_STORED;
            f.reject = 1'b0;
        end
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop     = q_valid && q_ready;
    assign q_data  = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) q_mem_reg[wr_ptr_reg] <= f;
    end

endmodule

// File: rtl/frt_back.sv
// ----------------------------------------------------------------------------
// frt_back
// Walks the slot table per fragment: lookup, purge and evict on a miss, place, report; rejects are only reported.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module frt_back #(
    parameter int TABLE_SLOTS = frt_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_PARTS   = frt_pkg::MAX_PARTS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [47:0]  timeout_time,
    input  logic [4:0]   pending_limit,
    input  logic         q_valid,
    output logic         q_ready,
    input  frt_pkg::frag_t q_data,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [2:0]   m_status,
    output logic [31:0]  m_done_stream_id,
    output logic [63:0]  m_done_frame_number,
    output logic [7:0]   m_done_part_total,
    output logic [23:0]  m_done_bytes
);
    import frt_pkg::*;

    localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW = $clog2(TABLE_SLOTS + 1);
    localparam int PW = (MAX_PARTS > 1) ? $clog2(MAX_PARTS) : 1;

    logic [TABLE_SLOTS-1:0] valid_reg;
    logic [63:0] key_reg    [TABLE_SLOTS];
    logic [31:0] fstr_reg   [TABLE_SLOTS];
    logic [63:0] ffrm_reg   [TABLE_SLOTS];
    logic [7:0]  ptot_reg   [TABLE_SLOTS];
    logic [7:0]  rcnt_reg   [TABLE_SLOTS];
    logic [MAX_PARTS-1:0] rmap_reg [TABLE_SLOTS];
    logic [47:0] arr_reg    [TABLE_SLOTS];
    logic [23:0] bsum_reg   [TABLE_SLOTS];

    bstate_t state_reg, state_next;
    frag_t   cur_reg;
    logic [SW-1:0] idx_reg;
    logic          last_idx;
    logic          hit_reg;
    logic [SW-1:0] slot_reg;
    logic [CW-1:0] used_reg;
    logic          pick_ok_reg;
    logic [SW-1:0] pick_reg;
    logic [47:0]   best_reg;
    logic [63:0]   key;
    logic [47:0]   age;
    logic [CW-1:0] limit;
    logic          out_valid_reg;
    logic [2:0]    o_status_reg;
    logic [31:0]   o_str_reg;
    logic [63:0]   o_frm_reg;
    logic [7:0]    o_tot_reg;
    logic [23:0]   o_bytes_reg;
    logic          free_ok;
    logic [SW-1:0] free_slot;
    logic          take;

    assign key      = {cur_reg.stream_id, 32'd0} ^ cur_reg.frame_number;
    assign age      = cur_reg.now_time - arr_reg[idx_reg];
    assign last_idx = (32'(idx_reg) == TABLE_SLOTS - 1);

    always_comb begin
        if (pending_limit == 5'd0)
            limit = CW'(1);
        else if (32'(pending_limit) > TABLE_SLOTS)
            limit = CW'(TABLE_SLOTS);
        else
            limit = CW'(pending_limit);
    end

    // Lowest free slot: priority encoder over the valid bits.
    always_comb begin
        free_ok   = 1'b0;
        free_slot = '0;
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_ok   = 1'b1;
                free_slot = SW'(i);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:   if (take) state_next = q_data.reject ? B_OUT : B_LOOKUP;
            B_LOOKUP: if (valid_reg[idx_reg] && key_reg[idx_reg] == key)
                          state_next = B_APPLY;
                      else if (last_idx) state_next = B_PURGE;
            B_PURGE:  if (last_idx) state_next = B_EVICT;
            B_EVICT:  if (last_idx) state_next = B_APPLY;
            B_APPLY:  state_next = B_OUT;
            B_OUT:    if (!out_valid_reg) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    // Hold the queue while the previous result still waits for its beat.
    always_comb begin
        q_ready = (state_reg == B_IDLE) && !out_valid_reg;
    end

    assign take = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else begin
            state_reg <= state_next;
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE: begin
                    idx_reg <= '0;
                    if (take) begin
                        cur_reg      <= q_data;
                        o_status_reg <= q_data.status;
                        o_str_reg    <= '0;
                        o_frm_reg    <= '0;
                        o_tot_reg    <= '0;
                        o_bytes_reg  <= '0;
                        hit_reg      <= 1'b0;
                    end
                end
                B_LOOKUP: begin
                    if (valid_reg[idx_reg] && key_reg[idx_reg] == key) begin
                        hit_reg  <= 1'b1;
                        slot_reg <= idx_reg;
                    end else begin
                        idx_reg <= last_idx ? '0 : idx_reg + SW'(1);
                    end
                    used_reg    <= '0;
                    pick_ok_reg <= 1'b0;
                    best_reg    <= '0;
                end
                B_PURGE: begin
                    // Drop stale entries, count survivors.
                    if (valid_reg[idx_reg]) begin
                        if (age > timeout_time) valid_reg[idx_reg] <= 1'b0;
                        else used_reg <= used_reg + CW'(1);
                    end
                    idx_reg <= last_idx ? '0 : idx_reg + SW'(1);
                end
                B_EVICT: begin
                    if (used_reg >= limit) begin
                        if (valid_reg[idx_reg] && (!pick_ok_reg || age > best_reg)) begin
                            pick_ok_reg <= 1'b1;
                            pick_reg    <= idx_reg;
                            best_reg    <= age;
                        end
                        if (last_idx) begin
                            if (valid_reg[idx_reg] && (!pick_ok_reg || age > best_reg))
                                valid_reg[idx_reg] <= 1'b0;
                            else if (pick_ok_reg)
                                valid_reg[pick_reg] <= 1'b0;
                        end
                    end
                    idx_reg <= last_idx ? '0 : idx_reg + SW'(1);
                end
                B_APPLY: begin
                    if (hit_reg) begin
                        if (cur_reg.part_index >= ptot_reg[slot_reg]) begin
                            o_status_reg <= ST_BAD;
                        end else if (rmap_reg[slot_reg][cur_reg.part_index[PW-1:0]]) begin
                            o_status_reg <= ST_DUP;
                        end else begin
                            rmap_reg[slot_reg][cur_reg.part_index[PW-1:0]] <= 1'b1;
                            rcnt_reg[slot_reg] <= rcnt_reg[slot_reg] + 8'd1;
                            bsum_reg[slot_reg] <= bsum_reg[slot_reg] +
                                                  24'(cur_reg.payload);
                            if (rcnt_reg[slot_reg] + 8'd1 == ptot_reg[slot_reg]) begin
                                o_status_reg <= ST_COMPLETE;
                                o_str_reg    <= fstr_reg[slot_reg];
                                o_frm_reg    <= ffrm_reg[slot_reg];
                                o_tot_reg    <= ptot_reg[slot_reg];
                                o_bytes_reg  <= bsum_reg[slot_reg] + 24'(cur_reg.payload);
                                valid_reg[slot_reg] <= 1'b0;
                            end else begin
                                o_status_reg <= ST_STORED;
                            end
                        end
                    end else begin
                        // New frame: index already checked against its own count.
                        key_reg[free_slot]  <= key;
                        fstr_reg[free_slot] <= cur_reg.stream_id;
                        ffrm_reg[free_slot] <= cur_reg.frame_number;
                        ptot_reg[free_slot] <= cur_reg.part_total;
                        arr_reg[free_slot]  <= cur_reg.now_time;
                        rmap_reg[free_slot] <= MAX_PARTS'(1) << cur_reg.part_index[PW-1:0];
                        rcnt_reg[free_slot] <= 8'd1;
                        bsum_reg[free_slot] <= 24'(cur_reg.payload);
                        if (cur_reg.part_total == 8'd1) begin
                            o_status_reg <= ST_COMPLETE;
                            o_str_reg    <= cur_reg.stream_id;
                            o_frm_reg    <= cur_reg.frame_number;
                            o_tot_reg    <= cur_reg.part_total;
                            o_bytes_reg  <= 24'(cur_reg.payload);
                        end else begin
                            o_status_reg <= ST_STORED;
                            valid_reg[free_slot] <= free_ok;
                        end
                    end
                end
                B_OUT: begin
                    if (!out_valid_reg) out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign m_valid             = out_valid_reg;
    assign m_status            = o_status_reg;
    assign m_done_stream_id    = o_str_reg;
    assign m_done_frame_number = o_frm_reg;
    assign m_done_part_total   = o_tot_reg;
    assign m_done_bytes        = o_bytes_reg;

    `ASSERT_IMPL(a_new_has_room, aclk, aresetn,
        (state_reg == B_APPLY && !hit_reg) |-> free_ok, "no free slot for new frame")
    `ASSERT_NEVER(a_take_while_busy, aclk, aresetn,
        q_ready && out_valid_reg, "queue pop while result pending")
    `ASSERT_IMPL(a_out_hold, aclk, aresetn,
        (out_valid_reg && !m_ready) |=> out_valid_reg, "result dropped")

endmodule

// File: rtl/fragment_reassembly_tracker.sv
// Throughput: one fragment per pass of the back end; its lookup, purge and eviction
// scans visit one slot a cycle. Rejected fragments skip the scans; a new fragment waits until the last result is taken.
// Reset clears the slot valid bits, queue and result valid flag at once; no sweep.
// ----------------------------------------------------------------------------
// fragment_reassembly_tracker
// Tracks pending fragmented frames and reports a status per fragment: short, bad, duplicate, stored or complete.
// ----------------------------------------------------------------------------
module fragment_reassembly_tracker #(
    parameter int TABLE_SLOTS  = frt_pkg::TABLE_SLOTS_DEF,
    parameter int MAX_PARTS    = frt_pkg::MAX_PARTS_DEF,
    parameter int HEADER_BYTES = frt_pkg::HEADER_BYTES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [47:0]  cfg_data,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [31:0]  s_stream_id,
    input  logic [63:0]  s_frame_number,
    input  logic [7:0]   s_part_index,
    input  logic [7:0]   s_part_total,
    input  logic [15:0]  s_packet_bytes,
    input  logic [47:0]  s_now_time,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [2:0]   m_status,
    output logic [31:0]  m_done_stream_id,
    output logic [63:0]  m_done_frame_number,
    output logic [7:0]   m_done_part_total,
    output logic [23:0]  m_done_bytes
);
    import frt_pkg::*;

    logic [47:0] timeout_reg;
    logic [4:0]  limit_reg;
    logic        q_valid, q_ready;
    frag_t       q_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            limit_reg   <= LIMIT_RESET;
        end else if (cfg_we) begin
            if (cfg_index == REG_TIMEOUT) timeout_reg <= cfg_data;
            if (cfg_index == REG_LIMIT)   limit_reg   <= cfg_data[4:0];
        end
    end

    frt_front #(.MAX_PARTS(MAX_PARTS), .HEADER_BYTES(HEADER_BYTES)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_stream_id, .s_frame_number,
        .s_part_index, .s_part_total, .s_packet_bytes, .s_now_time,
        .q_valid, .q_ready, .q_data
    );

    frt_back #(.TABLE_SLOTS(TABLE_SLOTS), .MAX_PARTS(MAX_PARTS)) u_back (
        .aclk, .aresetn, .timeout_time(timeout_reg), .pending_limit(limit_reg),
        .q_valid, .q_ready, .q_data, .m_valid, .m_ready, .m_status,
        .m_done_stream_id, .m_done_frame_number, .m_done_part_total, .m_done_bytes
    );

endmodule
